// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the breakpoint match table RTL.
// Depends on nothing; the including module must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define BMT_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define BMT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BMT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/bmt_pkg.sv =====
// Shared types and operation codes for the breakpoint match table.
// Used by bmt_cell and breakpoint_match_table; depends on nothing.
package bmt_pkg;

    localparam int ADDR_W = 16;
    localparam int SLOT_W = 6;
    // Wide enough for any slot index of the largest supported table.
    localparam int IDX_W  = 8;

    typedef logic [1:0]        kind_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [IDX_W-1:0]  idx_t;

    localparam kind_t KIND_CHECK  = 2'd0;
    localparam kind_t KIND_ADD    = 2'd1;
    localparam kind_t KIND_DELETE = 2'd2;

    typedef struct packed {
        kind_t kind;
        addr_t address;
    } req_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              status;
    } rsp_t;

    // Token that travels down the cell row, collecting search results.
    typedef struct packed {
        logic  valid;
        kind_t kind;
        addr_t address;
        logic  match_found;
        idx_t  match_idx;
        logic  free_found;
        idx_t  free_idx;
    } scan_t;

    // Write of a new breakpoint into one slot.
    typedef struct packed {
        logic  en;
        idx_t  idx;
        addr_t address;
    } commit_t;

endpackage

// ===== hdl/bmt_cell.sv =====
// One slot of the breakpoint match table and its stage of the search token.
// Depends on bmt_pkg.
module bmt_cell #(
    parameter int INDEX = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  bmt_pkg::scan_t    scan_in,
    input  bmt_pkg::commit_t  commit,
    output bmt_pkg::scan_t    scan_out
);

    localparam bmt_pkg::idx_t MY_IDX = bmt_pkg::idx_t'(INDEX);

    bmt_pkg::addr_t entry_reg;
    bmt_pkg::addr_t entry_next;
    bmt_pkg::scan_t scan_reg;
    bmt_pkg::scan_t scan_next;
    logic           match;
    logic           is_free;

    assign match   = scan_in.valid && (entry_reg == scan_in.address);
    assign is_free = (entry_reg == '0);

    always_comb
    begin
        scan_next = scan_in;
        // The first hit or free slot along the row is the lowest index.
        if (match && !scan_in.match_found)
        begin
            scan_next.match_found = 1'b1;
            scan_next.match_idx   = MY_IDX;
        end
        if (scan_in.valid && is_free && !scan_in.free_found)
        begin
            scan_next.free_found = 1'b1;
            scan_next.free_idx   = MY_IDX;
        end
    end

    always_comb
    begin
        entry_next = entry_reg;
        if (match && (scan_in.kind == bmt_pkg::KIND_DELETE))
        begin
            entry_next = '0;
        end
        else if (commit.en && (commit.idx == MY_IDX))
        begin
            entry_next = commit.address;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
            scan_reg  <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
            scan_reg  <= scan_next;
        end
    end

    assign scan_out = scan_reg;

endmodule

// ===== hdl/breakpoint_match_table.sv =====
// Top level of the breakpoint match table: request sequencing and result register.
// Depends on bmt_pkg, bmt_cell and assert_macros.svh.

// The table holds ENTRIES breakpoint addresses, one per cell, in a row of cells
// that a search token walks through one cell per cycle; a stored zero marks a
// free slot and the whole table is free after reset. Each item is a check, an
// add or a delete of one address. A check reports hit when a slot holds the
// address (address zero never hits). An add returns the lowest slot already
// holding the address, otherwise writes it into the lowest free slot and
// returns that slot, or reports table full with status. A delete clears every
// matching slot. Items are handled one at a time. The token is launched on the
// accepting edge, then passes through each cell of the row in turn, is collected
// at the end of the row into the capture register, and the result is then
// written to the result register once that register is free. The next item is
// accepted in the cycle after the result is loaded, even if that result has not
// yet been taken.
`include "assert_macros.svh"

module breakpoint_match_table #(
    parameter int ENTRIES = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  bmt_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output bmt_pkg::rsp_t rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t            state_reg;
    bmt_pkg::scan_t    head_reg;
    bmt_pkg::scan_t    cap_reg;
    bmt_pkg::rsp_t     rsp_reg;
    logic              rsp_valid_reg;
    bmt_pkg::rsp_t     rsp_calc;
    bmt_pkg::commit_t  commit;
    logic              rsp_load;
    bmt_pkg::scan_t    scan_bus [0:ENTRIES];

    // The token enters the first cell from the head register and leaves
    // the last cell with the search outcome.
    assign scan_bus[0] = head_reg;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        bmt_cell #(
            .INDEX (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .scan_in  (scan_bus[i]),
            .commit   (commit),
            .scan_out (scan_bus[i+1])
        );
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The result register is free when empty or being emptied this cycle.
    assign rsp_load = (state_reg == S_FINISH) && (!rsp_valid_reg || rsp_ready);

    // An add that found neither the address nor a free slot reports full;
    // one that found only a free slot writes the address there.
    always_comb
    begin
        rsp_calc = '0;
        case (cap_reg.kind)
            bmt_pkg::KIND_CHECK:
            begin
                rsp_calc.hit = cap_reg.match_found && (cap_reg.address != '0);
            end
            bmt_pkg::KIND_ADD:
            begin
                if (cap_reg.match_found)
                begin
                    rsp_calc.slot = cap_reg.match_idx[bmt_pkg::SLOT_W-1:0];
                end
                else if (cap_reg.free_found)
                begin
                    rsp_calc.slot = cap_reg.free_idx[bmt_pkg::SLOT_W-1:0];
                end
                else
                begin
                    rsp_calc.status = 1'b1;
                end
            end
            default:
            begin
                rsp_calc = '0;
            end
        endcase
    end

    // The write lands in the cell on the same edge that loads the result,
    // before any later item can reach that cell.
    always_comb
    begin
        commit.en      = rsp_load && (cap_reg.kind == bmt_pkg::KIND_ADD)
                         && !cap_reg.match_found && cap_reg.free_found;
        commit.idx     = cap_reg.free_idx;
        commit.address = cap_reg.address;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            cap_reg       <= '0;
            rsp_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            // A token is launched only on the edge that accepts an item.
            head_reg.valid <= (state_reg == S_IDLE) && req_valid;
            // The result stays on offer until it is taken.
            rsp_valid_reg  <= rsp_load || (rsp_valid_reg && !rsp_ready);
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        head_reg.kind        <= req.kind;
                        head_reg.address     <= req.address;
                        head_reg.match_found <= 1'b0;
                        head_reg.match_idx   <= '0;
                        head_reg.free_found  <= 1'b0;
                        head_reg.free_idx    <= '0;
                        state_reg            <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (scan_bus[ENTRIES].valid)
                    begin
                        cap_reg   <= scan_bus[ENTRIES];
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    if (rsp_load)
                    begin
                        rsp_reg   <= rsp_calc;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // The token only leaves the row while the sequencer is waiting for it.
    `BMT_ASSERT_IMP(a_tail_in_scan, scan_bus[ENTRIES].valid, state_reg == S_SCAN, "token left row outside scan")
    // An accepted item launches a token on the next edge.
    `BMT_ASSERT_NEXT(a_launch, req_valid && req_ready, head_reg.valid && (state_reg == S_SCAN), "item not launched")
    // A full or hit result never carries a slot number.
    `BMT_ASSERT_IMP(a_rsp_clean, rsp_valid && (rsp.status || rsp.hit), (rsp.slot == '0) && !(rsp.status && rsp.hit), "inconsistent result fields")

endmodule
